/* sv/emr_pkg.sv */
// shared constants for the midpoint ellipse rasterizer
`timescale 1ns / 1ps

package emr_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int RADIUS_BITS_DEF = 11;
    localparam int ACCUM_BITS_DEF  = 48;
    localparam int COLOR_BITS      = 24;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

endpackage

/* sv/emr_cmd_if.sv */
// command channel carrying start and step items
`timescale 1ns / 1ps

interface emr_cmd_if #(
    parameter int COORD_BITS  = emr_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = emr_pkg::RADIUS_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic        [RADIUS_BITS-1:0] radius_x;
    logic        [RADIUS_BITS-1:0] radius_y;

    modport source (
        output valid, operation, center_x, center_y, radius_x, radius_y,
        input  ready
    );
    modport sink (
        input  valid, operation, center_x, center_y, radius_x, radius_y,
        output ready
    );
endinterface

/* sv/emr_pix_if.sv */
// pixel channel carrying one painted pixel per item
`timescale 1ns / 1ps

interface emr_pix_if #(
    parameter int COORD_BITS = emr_pkg::COORD_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic signed [COORD_BITS-1:0]     pixel_x;
    logic signed [COORD_BITS-1:0]     pixel_y;
    logic [emr_pkg::COLOR_BITS-1:0]   pixel_color;
    logic                             last_of_step;
    logic                             ellipse_done;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_of_step, ellipse_done,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_of_step, ellipse_done,
        output ready
    );
endinterface

/* sv/emr_mul.sv */
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module emr_mul #(
    parameter int WIDTH = 2 * emr_pkg::RADIUS_BITS_DEF + 7
) (
    input  logic                        i_clk,
    input  logic signed [WIDTH-1:0]     i_a,
    input  logic signed [WIDTH-1:0]     i_b,
    output logic signed [2*WIDTH-1:0]   o_p
);
    logic signed [2*WIDTH-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

/* sv/midpoint_ellipse_rasterizer_core.sv */
// midpoint ellipse rasterizer top level: sequencer, decision update, pixel output
//
//  port        dir  kind        contents
//  i_cmd       in   valid/ready operation, center_x, center_y, radius_x, radius_y
//  o_pix       out  valid/ready pixel_x, pixel_y, pixel_color, last_of_step, ellipse_done
//  i_cfg_*     in   write only  stroke_color
//
//  a step item emits one pixel per cycle while o_pix is not stalled (4 on the ellipse, 1 on
//  degenerate shapes), paced by the single output register
//  a start item with both axes nonzero runs a setup sequence on the shared multiplier;
//  the step that enters region 2 adds a multiplier sequence after its pixels
//  i_cmd.ready is low from acceptance until the last pixel is loaded into the output
//  register and any multiplier sequence is over
//  a stalled o_pix holds its pixel; reset is synchronous, active low
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_core #(
    parameter int COORD_BITS  = emr_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = emr_pkg::RADIUS_BITS_DEF,
    parameter int ACCUM_BITS  = emr_pkg::ACCUM_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    emr_cmd_if.sink                        i_cmd,
    emr_pix_if.source                      o_pix,
    input  logic                           i_cfg_we,
    input  logic [emr_pkg::COLOR_BITS-1:0] i_cfg_data
);
    localparam int WALK_BITS = RADIUS_BITS + 2;
    localparam int LINE_BITS = RADIUS_BITS + 1;
    localparam int SQ_BITS   = 2 * RADIUS_BITS;
    localparam int MUL_BITS  = 2 * RADIUS_BITS + 7;

    typedef logic signed [ACCUM_BITS-1:0] t_acc;
    typedef logic signed [WALK_BITS-1:0]  t_walk;
    typedef logic signed [LINE_BITS-1:0]  t_line;
    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [MUL_BITS-1:0]   t_mop;
    typedef logic        [SQ_BITS-1:0]    t_sq;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SETUP  = 4'b0010,
        ST_EMIT   = 4'b0100,
        ST_SWITCH = 4'b1000
    } t_seq;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_POINT   = 6'b000010,
        PH_VLINE   = 6'b000100,
        PH_HLINE   = 6'b001000,
        PH_REGION1 = 6'b010000,
        PH_REGION2 = 6'b100000
    } t_phase;

    t_seq   r_seq,   n_seq;
    t_phase r_phase, n_phase;
    logic [2:0] r_ms, n_ms;
    logic [1:0] r_k, n_k;
    logic [1:0] r_nlast, n_nlast;
    logic       r_fin, n_fin;
    logic       r_sw, n_sw;
    logic       r_ov, n_ov;
    logic [emr_pkg::COLOR_BITS-1:0] r_color, n_color;

    t_coord r_cx, n_cx, r_cy, n_cy;
    logic [RADIUS_BITS-1:0] r_rx, n_rx, r_ry, n_ry;
    t_walk  r_wx, n_wx, r_wy, n_wy;
    t_walk  r_px, n_px, r_py, n_py;
    t_line  r_le, n_le;
    t_sq    r_rx2, n_rx2, r_ry2, n_ry2;
    t_acc   r_sax, n_sax, r_say, n_say, r_dec, n_dec;
    t_mop   r_sqa, n_sqa, r_sqb, n_sqb;

    t_coord r_ox, n_ox, r_oy, n_oy;
    logic [emr_pkg::COLOR_BITS-1:0] r_ocolor, n_ocolor;
    logic   r_olast, n_olast, r_odone, n_odone;

    t_mop                   mul_a, mul_b;
    logic signed [2*MUL_BITS-1:0] mul_p;

    logic acc;

    emr_mul #(.WIDTH(MUL_BITS)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign i_cmd.ready = (r_seq == ST_IDLE);
    assign acc         = i_cmd.valid && i_cmd.ready;

    assign o_pix.valid        = r_ov;
    assign o_pix.pixel_x      = r_ox;
    assign o_pix.pixel_y      = r_oy;
    assign o_pix.pixel_color  = r_ocolor;
    assign o_pix.last_of_step = r_olast;
    assign o_pix.ellipse_done = r_odone;

    always_comb begin
        t_acc   two_ry2;
        t_acc   two_rx2;
        t_acc   rx2a;
        t_acc   ry2a;
        t_acc   prod;
        t_acc   sax1;
        t_acc   say1;
        t_walk  wy1;
        t_walk  pos;
        t_coord dxc;
        t_coord dyc;
        logic   load;
        logic   last;

        n_seq    = r_seq;
        n_phase  = r_phase;
        n_ms     = r_ms;
        n_k      = r_k;
        n_nlast  = r_nlast;
        n_fin    = r_fin;
        n_sw     = r_sw;
        n_ov     = r_ov;
        n_color  = r_color;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_rx     = r_rx;
        n_ry     = r_ry;
        n_wx     = r_wx;
        n_wy     = r_wy;
        n_px     = r_px;
        n_py     = r_py;
        n_le     = r_le;
        n_rx2    = r_rx2;
        n_ry2    = r_ry2;
        n_sax    = r_sax;
        n_say    = r_say;
        n_dec    = r_dec;
        n_sqa    = r_sqa;
        n_sqb    = r_sqb;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_ocolor = r_ocolor;
        n_olast  = r_olast;
        n_odone  = r_odone;
        mul_a    = '0;
        mul_b    = '0;

        two_ry2 = t_acc'(r_ry2) <<< 1;
        two_rx2 = t_acc'(r_rx2) <<< 1;
        rx2a    = t_acc'(r_rx2);
        ry2a    = t_acc'(r_ry2);
        prod    = t_acc'(mul_p);
        sax1    = r_sax;
        say1    = r_say;
        wy1     = r_wy;
        pos     = '0;
        dxc     = t_coord'(r_px);
        dyc     = t_coord'(r_py);
        load    = 1'b0;
        last    = 1'b0;

        if (i_cfg_we) begin
            n_color = i_cfg_data;
        end

        if (r_ov && o_pix.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_seq)
            ST_IDLE: begin
                if (acc && i_cmd.operation == emr_pkg::OP_START) begin
                    n_cx  = i_cmd.center_x;
                    n_cy  = i_cmd.center_y;
                    n_rx  = i_cmd.radius_x;
                    n_ry  = i_cmd.radius_y;
                    n_wx  = '0;
                    n_wy  = '0;
                    n_le  = '0;
                    n_sax = '0;
                    n_say = '0;
                    n_dec = '0;
                    if (i_cmd.radius_x == '0 && i_cmd.radius_y == '0) begin
                        n_phase = PH_POINT;
                    end else if (i_cmd.radius_x == '0) begin
                        n_wy    = -t_walk'(i_cmd.radius_y);
                        n_le    = t_line'(i_cmd.radius_y);
                        n_phase = PH_VLINE;
                    end else if (i_cmd.radius_y == '0) begin
                        n_wx    = -t_walk'(i_cmd.radius_x);
                        n_le    = t_line'(i_cmd.radius_x);
                        n_phase = PH_HLINE;
                    end else begin
                        n_wy    = t_walk'(i_cmd.radius_y);
                        n_phase = PH_REGION1;
                        n_seq   = ST_SETUP;
                        n_ms    = '0;
                    end
                end else if (acc) begin
                    n_k   = '0;
                    n_sw  = 1'b0;
                    n_fin = 1'b0;
                    unique case (r_phase) inside
                        PH_POINT: begin
                            n_px    = '0;
                            n_py    = '0;
                            n_nlast = 2'd0;
                            n_fin   = 1'b1;
                            n_phase = PH_IDLE;
                            n_seq   = ST_EMIT;
                        end
                        PH_VLINE, PH_HLINE: begin
                            pos     = (r_phase == PH_VLINE) ? r_wy : r_wx;
                            n_px    = (r_phase == PH_VLINE) ? '0 : pos;
                            n_py    = (r_phase == PH_VLINE) ? pos : '0;
                            n_nlast = 2'd0;
                            n_fin   = (pos >= r_le);
                            n_seq   = ST_EMIT;
                            if (pos >= r_le) begin
                                n_phase = PH_IDLE;
                            end else if (r_phase == PH_VLINE) begin
                                n_wy = r_wy + t_walk'(1);
                            end else begin
                                n_wx = r_wx + t_walk'(1);
                            end
                        end
                        PH_REGION1: begin
                            n_px    = r_wx;
                            n_py    = r_wy;
                            n_nlast = 2'd3;
                            n_seq   = ST_EMIT;
                            n_wx    = r_wx + t_walk'(1);
                            sax1    = r_sax + two_ry2;
                            if (r_dec[ACCUM_BITS-1]) begin
                                n_dec = r_dec + ((sax1 + ry2a) <<< 2);
                            end else begin
                                n_wy  = r_wy - t_walk'(1);
                                say1  = r_say - two_rx2;
                                n_dec = r_dec + ((sax1 - say1 + ry2a) <<< 2);
                            end
                            n_sax = sax1;
                            n_say = say1;
                            n_sw  = !(sax1 < say1);
                        end
                        PH_REGION2: begin
                            n_px    = r_wx;
                            n_py    = r_wy;
                            n_nlast = 2'd3;
                            n_seq   = ST_EMIT;
                            wy1     = r_wy - t_walk'(1);
                            say1    = r_say - two_rx2;
                            if (!r_dec[ACCUM_BITS-1] && r_dec != '0) begin
                                n_dec = r_dec + ((rx2a - say1) <<< 2);
                            end else begin
                                n_wx  = r_wx + t_walk'(1);
                                sax1  = r_sax + two_ry2;
                                n_dec = r_dec + ((sax1 - say1 + rx2a) <<< 2);
                            end
                            n_wy  = wy1;
                            n_sax = sax1;
                            n_say = say1;
                            if (wy1 < 0) begin
                                n_fin   = 1'b1;
                                n_phase = PH_IDLE;
                            end
                        end
                        default: begin
                            n_seq = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SETUP: begin
                n_ms = r_ms + 3'd1;
                case (r_ms)
                    3'd0: begin
                        mul_a = t_mop'(r_rx);
                        mul_b = t_mop'(r_rx);
                    end
                    3'd1: begin
                        mul_a = t_mop'(r_ry);
                        mul_b = t_mop'(r_ry);
                        n_rx2 = t_sq'(mul_p);
                    end
                    3'd2: begin
                        mul_a = t_mop'(r_rx2);
                        mul_b = t_mop'(r_ry);
                        n_ry2 = t_sq'(mul_p);
                    end
                    default: begin
                        n_say = prod <<< 1;
                        n_dec = (ry2a <<< 2) - (prod <<< 2) + rx2a;
                        n_seq = ST_IDLE;
                    end
                endcase
            end
            ST_EMIT: begin
                load = !r_ov || o_pix.ready;
                last = (r_k == r_nlast);
                if (load) begin
                    n_ov     = 1'b1;
                    n_ox     = r_cx + (r_k[0] ? -dxc : dxc);
                    n_oy     = r_cy + (r_k[1] ? -dyc : dyc);
                    n_ocolor = r_color;
                    n_olast  = last;
                    n_odone  = last && r_fin;
                    n_k      = r_k + 2'd1;
                    if (last) begin
                        n_ms  = '0;
                        n_seq = r_sw ? ST_SWITCH : ST_IDLE;
                    end
                end
            end
            ST_SWITCH: begin
                n_ms = r_ms + 3'd1;
                case (r_ms)
                    3'd0: begin
                        mul_a = (t_mop'(r_wx) <<< 1) + t_mop'(1);
                        mul_b = (t_mop'(r_wx) <<< 1) + t_mop'(1);
                    end
                    3'd1: begin
                        mul_a = (t_mop'(r_wy) <<< 1) - t_mop'(2);
                        mul_b = (t_mop'(r_wy) <<< 1) - t_mop'(2);
                        n_sqa = t_mop'(mul_p);
                    end
                    3'd2: begin
                        mul_a = t_mop'(r_ry2);
                        mul_b = r_sqa;
                        n_sqb = t_mop'(mul_p);
                    end
                    3'd3: begin
                        mul_a = t_mop'(r_rx2);
                        mul_b = r_sqb;
                        n_dec = prod;
                    end
                    3'd4: begin
                        mul_a = t_mop'(r_rx2);
                        mul_b = t_mop'(r_ry2);
                        n_dec = r_dec + prod;
                    end
                    default: begin
                        n_dec   = r_dec - (prod <<< 2);
                        n_phase = PH_REGION2;
                        n_seq   = ST_IDLE;
                    end
                endcase
            end
            default: begin
                n_seq = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= ST_IDLE;
            r_phase <= PH_IDLE;
            r_ms    <= '0;
            r_k     <= '0;
            r_nlast <= '0;
            r_fin   <= 1'b0;
            r_sw    <= 1'b0;
            r_ov    <= 1'b0;
            r_color <= '0;
        end else begin
            r_seq   <= n_seq;
            r_phase <= n_phase;
            r_ms    <= n_ms;
            r_k     <= n_k;
            r_nlast <= n_nlast;
            r_fin   <= n_fin;
            r_sw    <= n_sw;
            r_ov    <= n_ov;
            r_color <= n_color;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_rx     <= n_rx;
        r_ry     <= n_ry;
        r_wx     <= n_wx;
        r_wy     <= n_wy;
        r_px     <= n_px;
        r_py     <= n_py;
        r_le     <= n_le;
        r_rx2    <= n_rx2;
        r_ry2    <= n_ry2;
        r_sax    <= n_sax;
        r_say    <= n_say;
        r_dec    <= n_dec;
        r_sqa    <= n_sqa;
        r_sqb    <= n_sqb;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_ocolor <= n_ocolor;
        r_olast  <= n_olast;
        r_odone  <= n_odone;
    end

    // done pixel always closes its step
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && o_pix.ellipse_done |-> o_pix.last_of_step)
        else $error("ellipse_done without last_of_step");

    // a start item never produces a pixel
    a_start_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_cmd.operation == emr_pkg::OP_START |=> !$rose(o_pix.valid))
        else $error("pixel after start item");

    // multiplier sequences never load the output register
    a_mul_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == ST_SWITCH || r_seq == ST_SETUP) |=> !$rose(o_pix.valid))
        else $error("pixel during multiplier sequence");

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase) && $onehot(r_seq))
        else $error("phase or sequencer code corrupt");

endmodule
